/* hdl/gbu_pkg.sv */
package gbu_pkg;

  localparam int PIX_W   = 8;
  localparam int COORD_W = 11;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_RESET = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // floor(s / 3) == (s * 683) >> 11 for s up to 765
  localparam int SUM_W       = 10;
  localparam int PROD_W      = 20;
  localparam int GREY_RECIP  = 683;
  localparam int GREY_SHIFT  = 11;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic [1:0] {
    K_DIAG,
    K_UP,
    K_LEFT,
    K_SELF
  } kind_e;

  typedef struct packed {
    logic [COORD_W-1:0] row2;
    logic [COORD_W-1:0] col2;
    logic               row_nz;
    logic               col_nz;
    logic [PIX_W-1:0]   grey;
    logic [PIX_W-1:0]   left;
    logic [PIX_W-1:0]   above;
    logic [PIX_W-1:0]   upper_left;
  } job_t;

endpackage

/* hdl/gbu_front.sv */
module gbu_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [gbu_pkg::PIX_W-1:0]       blue_i,
  input  logic [gbu_pkg::PIX_W-1:0]       green_i,
  input  logic [gbu_pkg::PIX_W-1:0]       red_i,
  input  logic                            cfg_valid_i,
  input  logic [gbu_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gbu_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output gbu_pkg::job_t                   q_job_o
);
  import gbu_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int DWW = $clog2(MAX_WIDTH + 1);
  localparam int DWH = $clog2(MAX_HEIGHT + 1);
  localparam int W_RST = (MAX_WIDTH < CFG_RESET) ? MAX_WIDTH : CFG_RESET;
  localparam int H_RST = (MAX_HEIGHT < CFG_RESET) ? MAX_HEIGHT : CFG_RESET;

  logic [DWW-1:0] width_q, w_clamp;
  logic [DWH-1:0] height_q, h_clamp;
  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic [PIX_W-1:0] left_q, ul_q;
  logic [DWW-1:0] col_inc;
  logic [DWH-1:0] row_inc;
  logic           wrap_col;
  logic           accept;
  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0]  grey;

  logic [PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_q;

  logic               s1_valid_q;
  logic [COORD_W-1:0] s1_row2_q, s1_col2_q;
  logic               s1_row_nz_q, s1_col_nz_q, s1_wrap_q;
  logic [PIX_W-1:0]   s1_grey_q, s1_left_q;
  logic [PIX_W-1:0]   above;

  always_comb begin
    if (cfg_data_i == '0) begin
      w_clamp = DWW'(1);
    end else if (32'(cfg_data_i) > 32'(MAX_WIDTH)) begin
      w_clamp = DWW'(MAX_WIDTH);
    end else begin
      w_clamp = DWW'(cfg_data_i);
    end
    if (cfg_data_i == '0) begin
      h_clamp = DWH'(1);
    end else if (32'(cfg_data_i) > 32'(MAX_HEIGHT)) begin
      h_clamp = DWH'(MAX_HEIGHT);
    end else begin
      h_clamp = DWH'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DWW'(W_RST);
      height_q <= DWH'(H_RST);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_IMAGE_WIDTH) begin
        width_q <= w_clamp;
      end
      if (cfg_index_i == REG_IMAGE_HEIGHT) begin
        height_q <= h_clamp;
      end
    end
  end

  assign q_push_o   = s1_valid_q && !q_full_i;
  assign in_ready_o = !s1_valid_q || !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign sum  = SUM_W'(blue_i) + SUM_W'(green_i) + SUM_W'(red_i);
  assign prod = PROD_W'(sum) * PROD_W'(GREY_RECIP);
  assign grey = prod[GREY_SHIFT +: PIX_W];

  assign col_inc  = DWW'(col_q) + DWW'(1);
  assign row_inc  = DWH'(row_q) + DWH'(1);
  assign wrap_col = col_inc >= width_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (wrap_col) begin
      col_d = '0;
      row_d = (row_inc >= height_q) ? '0 : RW'(row_inc);
    end else begin
      col_d = CW'(col_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else if (accept) begin
      col_q  <= col_d;
      row_q  <= row_d;
      left_q <= wrap_col ? '0 : grey;
    end
  end

  // read-first line buffer: previous row at this column, then overwrite
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q           <= line_mem[col_q];
      line_mem[col_q] <= grey;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_row2_q   <= COORD_W'({row_q, 1'b0});
      s1_col2_q   <= COORD_W'({col_q, 1'b0});
      s1_row_nz_q <= row_q != '0;
      s1_col_nz_q <= col_q != '0;
      s1_wrap_q   <= wrap_col;
      s1_grey_q   <= grey;
      s1_left_q   <= left_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (q_push_o) begin
      s1_valid_q <= 1'b0;
    end
  end

  assign above = s1_row_nz_q ? rd_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ul_q <= '0;
    end else if (q_push_o) begin
      ul_q <= s1_wrap_q ? '0 : above;
    end
  end

  always_comb begin
    q_job_o.row2       = s1_row2_q;
    q_job_o.col2       = s1_col2_q;
    q_job_o.row_nz     = s1_row_nz_q;
    q_job_o.col_nz     = s1_col_nz_q;
    q_job_o.grey       = s1_grey_q;
    q_job_o.left       = s1_left_q;
    q_job_o.above      = above;
    q_job_o.upper_left = ul_q;
  end

endmodule

/* hdl/gbu_queue.sv */
module gbu_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gbu_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output gbu_pkg::job_t head_o
);
  import gbu_pkg::*;

  job_t              slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign full_o  = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QPTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

/* hdl/gbu_back.sv */
module gbu_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  gbu_pkg::job_t                 head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gbu_pkg::COORD_W-1:0]   out_row_o,
  output logic [gbu_pkg::COORD_W-1:0]   out_col_o,
  output logic [gbu_pkg::PIX_W-1:0]     grey_value_o,
  output logic                          last_of_run_o
);
  import gbu_pkg::*;

  kind_e step_q, step_d, cur;
  logic  load;
  logic  has_diag, has_up, has_left;
  logic [PIX_W:0] upper_sum, lower_sum, vert_sum, mid_sum;
  logic [PIX_W-1:0] upper_mid, lower_mid;
  logic [COORD_W-1:0] row_v, col_v;
  logic [PIX_W-1:0]   grey_v;

  logic               out_valid_q;
  logic [COORD_W-1:0] out_row_q, out_col_q;
  logic [PIX_W-1:0]   grey_q;
  logic               last_q;

  assign has_up   = head_i.row_nz;
  assign has_left = head_i.col_nz;
  assign has_diag = has_up && has_left;

  always_comb begin
    unique case (step_q)
      K_DIAG: cur = has_diag ? K_DIAG : (has_up ? K_UP : (has_left ? K_LEFT : K_SELF));
      K_UP:   cur = has_up ? K_UP : (has_left ? K_LEFT : K_SELF);
      K_LEFT: cur = has_left ? K_LEFT : K_SELF;
      K_SELF: cur = K_SELF;
      default: cur = K_SELF;
    endcase
  end

  assign upper_sum = (PIX_W + 1)'(head_i.upper_left) + (PIX_W + 1)'(head_i.above);
  assign lower_sum = (PIX_W + 1)'(head_i.left) + (PIX_W + 1)'(head_i.grey);
  assign vert_sum  = (PIX_W + 1)'(head_i.above) + (PIX_W + 1)'(head_i.grey);
  assign upper_mid = upper_sum[PIX_W:1];
  assign lower_mid = lower_sum[PIX_W:1];
  assign mid_sum   = (PIX_W + 1)'(upper_mid) + (PIX_W + 1)'(lower_mid);

  always_comb begin
    row_v  = head_i.row2;
    col_v  = head_i.col2;
    grey_v = head_i.grey;
    step_d = K_DIAG;
    unique case (cur)
      K_DIAG: begin
        row_v  = head_i.row2 - COORD_W'(1);
        col_v  = head_i.col2 - COORD_W'(1);
        grey_v = mid_sum[PIX_W:1];
        step_d = K_UP;
      end
      K_UP: begin
        row_v  = head_i.row2 - COORD_W'(1);
        grey_v = vert_sum[PIX_W:1];
        step_d = K_LEFT;
      end
      K_LEFT: begin
        col_v  = head_i.col2 - COORD_W'(1);
        grey_v = lower_mid;
        step_d = K_SELF;
      end
      K_SELF: begin
        step_d = K_DIAG;
      end
      default: begin
        step_d = K_DIAG;
      end
    endcase
  end

  assign load  = !empty_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && (cur == K_SELF);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= K_DIAG;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        step_q      <= step_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_row_q <= row_v;
      out_col_q <= col_v;
      grey_q    <= grey_v;
      last_q    <= cur == K_SELF;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_row_o     = out_row_q;
  assign out_col_o     = out_col_q;
  assign grey_value_o  = grey_q;
  assign last_of_run_o = last_q;

endmodule

/* hdl/grey_bilinear_upscale_2x.sv */
// a pixel beat passes the front stage register, the job queue and the output register;
// each pixel gives 1, 2 or 4 result beats, and the output register moves one result beat
//   a cycle while out_ready_i is high; the job queue lets the front run ahead
// reset: position counters and neighbor registers clear, image size returns to 1024
//   (clamped to the maximum), the line buffer is not cleared
module grey_bilinear_upscale_2x #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gbu_pkg::PIX_W-1:0]     blue_i,
  input  logic [gbu_pkg::PIX_W-1:0]     green_i,
  input  logic [gbu_pkg::PIX_W-1:0]     red_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gbu_pkg::COORD_W-1:0]   out_row_o,
  output logic [gbu_pkg::COORD_W-1:0]   out_col_o,
  output logic [gbu_pkg::PIX_W-1:0]     grey_value_o,
  output logic                          last_of_run_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gbu_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gbu_pkg::CFG_W-1:0]     cfg_data_i
);
  import gbu_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  job_t q_job, q_head;

  assign cfg_ready_o = 1'b1;

  gbu_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .blue_i     (blue_i),
    .green_i    (green_i),
    .red_i      (red_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (q_job)
  );

  gbu_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (q_job),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .head_o (q_head)
  );

  gbu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .grey_value_o (grey_value_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

/* verif/tb_grey_bilinear_upscale_2x.sv */
module tb_grey_bilinear_upscale_2x;
  timeunit 1ns;
  timeprecision 1ps;

  import gbu_pkg::*;

  localparam int unsigned MAX_DIM      = 1024;
  localparam int unsigned LONG_DIM     = 40;
  localparam int unsigned RANDOM_ITEMS = 290;
  localparam int unsigned SETTLE_WAIT  = 8;
  localparam int unsigned END_WAIT     = 20;
  localparam int unsigned CYCLE_LIMIT  = 3000000;
  localparam int unsigned HOLD_OFF     = 150;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   grey;
    logic               last;
  } zoomed_pixel_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [PIX_W-1:0]     blue_i      = '0;
  logic [PIX_W-1:0]     green_i     = '0;
  logic [PIX_W-1:0]     red_i       = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [COORD_W-1:0]   out_row_o;
  logic [COORD_W-1:0]   out_col_o;
  logic [PIX_W-1:0]     grey_value_o;
  logic                 last_of_run_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i  = '0;

  grey_bilinear_upscale_2x uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .blue_i        (blue_i),
    .green_i       (green_i),
    .red_i         (red_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .grey_value_o  (grey_value_o),
    .last_of_run_o (last_of_run_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // upscaler state as seen from outside
  logic [CFG_W-1:0] width_reg  = CFG_W'(CFG_RESET);
  logic [CFG_W-1:0] height_reg = CFG_W'(CFG_RESET);
  logic [PIX_W-1:0] line_grey [MAX_DIM];
  int unsigned      next_row        = 0;
  int unsigned      next_col        = 0;
  int unsigned      left_grey       = 0;
  int unsigned      upper_left_grey = 0;

  zoomed_pixel_t zoomed_q [$];

  int unsigned error_count     = 0;
  int unsigned cycle_count     = 0;
  int unsigned hold_off_cycles = 0;
  bit          tx_idle_on      = 1'b1;
  bit          rx_idle_on      = 1'b1;

  initial begin
    foreach (line_grey[i]) line_grey[i] = '0;
  end

  function automatic int unsigned clamp_size(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PIX_W-1:0] rand_component();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [CFG_W-1:0] random_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return CFG_W'($urandom_range(1, 6));
    if (r < 85) return CFG_W'($urandom_range(7, 32));
    if (r < 92) return '0;
    if (r < 96) return CFG_W'(MAX_DIM);
    return CFG_W'($urandom_range(MAX_DIM + 1, 2047));
  endfunction

  function automatic void expect_beat(int unsigned row, int unsigned col,
                                      int unsigned grey, logic last);
    zoomed_pixel_t px;
    px.row  = COORD_W'(row);
    px.col  = COORD_W'(col);
    px.grey = PIX_W'(grey);
    px.last = last;
    zoomed_q.push_back(px);
  endfunction

  task automatic zoom_pixel(input logic [PIX_W-1:0] b, g, r);
    int unsigned w, h, sum, grey, row, col, above, upper_mid, lower_mid;
    w = clamp_size(width_reg);
    h = clamp_size(height_reg);
    sum = 32'(b);
    sum += 32'(g);
    sum += 32'(r);
    grey = sum / 3;
    row = next_row;
    col = next_col;
    if (col >= MAX_DIM) col = MAX_DIM - 1;
    above = 0;
    if (row > 0) above = 32'(line_grey[col]);
    if (row > 0 && col > 0) begin
      upper_mid = (upper_left_grey + above) / 2;
      lower_mid = (left_grey + grey) / 2;
      expect_beat(2 * row - 1, 2 * col - 1, (upper_mid + lower_mid) / 2, 1'b0);
    end
    if (row > 0) expect_beat(2 * row - 1, 2 * col, (above + grey) / 2, 1'b0);
    if (col > 0) expect_beat(2 * row, 2 * col - 1, (left_grey + grey) / 2, 1'b0);
    expect_beat(2 * row, 2 * col, grey, 1'b1);
    upper_left_grey = above;
    line_grey[col] = PIX_W'(grey);
    left_grey = grey;
    if (col + 1 >= w) begin
      next_col = 0;
      left_grey = 0;
      upper_left_grey = 0;
      next_row = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      next_col = col + 1;
    end
  endtask

  task automatic report(input string msg);
    if (error_count < 100) $display("mismatch: %s", msg);
    error_count++;
  endtask

  task automatic pause_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic idle_input(input int n);
    if (n > 0) begin
      pause_input();
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] b, g, r);
    if (tx_idle_on) idle_input(pick_gap());
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    blue_i     <= b;
    green_i    <= g;
    red_i      <= r;
    do @(posedge clk_i); while (!in_ready_o);
    zoom_pixel(b, g, r);
  endtask

  task automatic send_random_pixel();
    send_pixel(rand_component(), rand_component(), rand_component());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_IMAGE_WIDTH:  width_reg = data;
      REG_IMAGE_HEIGHT: height_reg = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle();
    pause_input();
    while (zoomed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  // a wider row below the first row would read line entries never written
  task automatic resize(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    settle();
    if (next_row == 0 || clamp_size(w) <= clamp_size(width_reg))
      write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  task automatic finish_frame();
    while (next_row != 0 || next_col != 0) send_random_pixel();
  endtask

  task automatic test_reset_size();
    send_pixel('0, '0, '0);
    send_pixel('1, '1, '1);
    send_pixel('1, '0, 8'd128);
  endtask

  task automatic test_register_limits();
    resize('0, '0);
    send_pixel('1, '1, '1);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel('0, '1, '0);
    resize('1, '1);
    write_reg(REG_SPARE_A, CFG_W'($urandom_range(0, 2047)));
    write_reg(REG_SPARE_B, CFG_W'($urandom_range(0, 2047)));
    send_pixel('1, '1, 8'd254);
    send_pixel('0, '0, 8'd2);
  endtask

  task automatic test_small_frame();
    logic [3*PIX_W-1:0] pattern [7];
    pattern = '{24'hFFFFFF, 24'h000000, 24'hFFFFFE, 24'h010000,
                24'hFFFFFF, 24'h000001, 24'h804020};
    resize(CFG_W'(3), CFG_W'(2));
    finish_frame();
    foreach (pattern[i]) send_pixel(pattern[i][23:16], pattern[i][15:8], pattern[i][7:0]);
  endtask

  task automatic test_mid_frame_resize();
    resize(CFG_W'(4), CFG_W'(3));
    repeat (5) send_random_pixel();
    resize(CFG_W'(2), CFG_W'(1));
    repeat (2) send_random_pixel();
  endtask

  task automatic test_full_row();
    resize(CFG_W'(LONG_DIM), CFG_W'(1));
    do send_random_pixel(); while (next_col != 0);
    send_random_pixel();
  endtask

  task automatic test_full_column();
    resize(CFG_W'(1), CFG_W'(LONG_DIM));
    do send_random_pixel(); while (next_row != 0);
    send_random_pixel();
  endtask

  task automatic test_backpressure();
    resize(CFG_W'(4), CFG_W'(3));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_off_cycles = HOLD_OFF;
    repeat (30) send_random_pixel();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    resize(CFG_W'(5), CFG_W'(4));
    repeat (12) send_random_pixel();
    pause_input();
    while (zoomed_q.size() != 0) @(posedge clk_i);
    repeat (12) send_random_pixel();
  endtask

  task automatic test_random();
    int unsigned sent, n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      resize(random_size(), random_size());
      if ($urandom_range(0, 5) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                  CFG_W'($urandom_range(0, 2047)));
      tx_idle_on = ($urandom_range(0, 2) != 0);
      rx_idle_on = ($urandom_range(0, 2) != 0);
      n = $urandom_range(10, 50);
      repeat (n) send_random_pixel();
      sent += n;
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles != 0) begin
        stall_left = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (rx_idle_on) stall_left = unsigned'(pick_gap());
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    zoomed_pixel_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (zoomed_q.size() == 0) begin
        report($sformatf("unexpected beat row %0d col %0d grey %0d",
                         out_row_o, out_col_o, grey_value_o));
      end else begin
        want = zoomed_q.pop_front();
        if (out_row_o !== want.row)
          report($sformatf("out_row got %0d expected %0d", out_row_o, want.row));
        if (out_col_o !== want.col)
          report($sformatf("out_col got %0d expected %0d", out_col_o, want.col));
        if (grey_value_o !== want.grey)
          report($sformatf("grey_value at (%0d,%0d) got %0d expected %0d",
                           want.row, want.col, grey_value_o, want.grey));
        if (last_of_run_o !== want.last)
          report($sformatf("last_of_run at (%0d,%0d) got %0b expected %0b",
                           want.row, want.col, last_of_run_o, want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_size();
    test_register_limits();
    test_small_frame();
    test_mid_frame_resize();
    test_full_row();
    test_full_column();
    test_backpressure();
    test_drain_pause();
    test_random();

    settle();
    repeat (END_WAIT) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/gbu_pkg.sv
hdl/gbu_front.sv
hdl/gbu_queue.sv
hdl/gbu_back.sv
hdl/grey_bilinear_upscale_2x.sv
verif/tb_grey_bilinear_upscale_2x.sv
